@@ design/rpfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package rpfa_pkg;
  localparam int NUM_FRAMES = 1024;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int LINK_BITS = FRAME_BITS + 1;
  localparam int REF_BITS = 16;
  localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(NUM_FRAMES);
  localparam logic [REF_BITS-1:0] MAX_REF = '1;

  localparam logic [2:0] MODE_INSERT = 3'd0;
  localparam logic [2:0] MODE_ALLOC = 3'd1;
  localparam logic [2:0] MODE_HOLD = 3'd2;
  localparam logic [2:0] MODE_DROP = 3'd3;
  localparam logic [2:0] MODE_RELEASE = 3'd4;
  localparam logic [2:0] MODE_QUERY = 3'd5;
  localparam logic [2:0] MODE_RSVD_LO = 3'd6;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EXHAUSTED = 3'd1;
  localparam logic [2:0] ST_NOT_PRESENT = 3'd2;
  localparam logic [2:0] ST_ALREADY = 3'd3;
  localparam logic [2:0] ST_UNDERFLOW = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;
  localparam logic [2:0] ST_HELD = 3'd6;
  localparam logic [2:0] ST_RANGE = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_DECIDE, S_INS_RD, S_INS_WR, S_UNLINK, S_APPEND, S_DONE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic clear;     // clear next present mark
    logic load;      // capture input item
    logic rd;        // read memories at current frame
    logic ins_wr;    // insert current frame if absent
    logic ins_next;  // advance insert pointer
    logic decide;    // evaluate op from read data
    logic unlink;    // remove frame from list
    logic append;    // append frame to list
    logic out_load;  // present result
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_last;   // last present mark being cleared
    logic ins_ok;     // insert range valid
    logic ins_last;   // current is last of range
    logic do_unlink;
    logic do_append;
  } sts_t;
endpackage
`default_nettype wire

@@ design/rpfa_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rpfa_datapath import rpfa_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [2:0]            mode,
  input  wire logic [FRAME_BITS-1:0] frame,
  input  wire logic [10:0]           count,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic [FRAME_BITS-1:0]      result_frame,
  output logic [15:0]                ref_count,
  output logic [2:0]                 status,
  output logic [10:0]                free_frames
);
  logic [REF_BITS-1:0]  cnt_mem [NUM_FRAMES];
  logic [LINK_BITS-1:0] nxt_mem [NUM_FRAMES];
  logic [LINK_BITS-1:0] prv_mem [NUM_FRAMES];
  logic                 present [NUM_FRAMES];

  logic [FRAME_BITS-1:0] clr_idx;
  logic [2:0]            op;
  logic [FRAME_BITS-1:0] cur;
  logic [FRAME_BITS-1:0] first;
  logic [LINK_BITS-1:0]  last;
  logic [LINK_BITS-1:0]  head, tail, total;
  logic [2:0]            st;
  logic [REF_BITS-1:0]   rc_new;
  logic                  rd_pres;
  logic [REF_BITS-1:0]   rd_cnt;
  logic [LINK_BITS-1:0]  rd_nxt, rd_prv;
  logic                  unl, app;
  logic [FRAME_BITS-1:0] tgt;
  logic                  range_bad;

  assign range_bad = (count == 11'd0) || ({1'b0, frame} + count > 12'(NUM_FRAMES));

  assign sts.clr_last = (clr_idx == FRAME_BITS'(NUM_FRAMES - 1));
  assign sts.ins_ok = (st != ST_RANGE);
  assign sts.ins_last = ({1'b0, cur} == last);
  assign sts.do_unlink = unl;
  assign sts.do_append = app;

  // read port, registered
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_cnt <= cnt_mem[cur];
      rd_nxt <= nxt_mem[cur];
      rd_prv <= prv_mem[cur];
      rd_pres <= present[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      head <= NIL;
      tail <= NIL;
      total <= '0;
    end else begin
      if (cmd.clear) begin
        present[clr_idx] <= 1'b0;
        clr_idx <= clr_idx + 1'b1;
      end
      if (cmd.load) begin
        op <= mode;
        cur <= (mode == MODE_ALLOC) ? head[FRAME_BITS-1:0] : frame;
        first <= frame;
        last <= LINK_BITS'({1'b0, frame} + count - 12'd1);
        unl <= 1'b0;
        app <= 1'b0;
        rc_new <= '0;
        tgt <= frame;
        if (mode == MODE_INSERT)
          st <= range_bad ? ST_RANGE : ST_OK;
        else if (mode == MODE_ALLOC)
          st <= (head == NIL) ? ST_EXHAUSTED : ST_OK;
        else if (mode > MODE_QUERY)
          st <= ST_RANGE;
        else
          st <= ST_OK;
        if (mode == MODE_ALLOC) tgt <= (head == NIL) ? '0 : head[FRAME_BITS-1:0];
      end
      if (cmd.ins_wr && !rd_pres) begin
        present[cur] <= 1'b1;
        cnt_mem[cur] <= '0;
        nxt_mem[cur] <= NIL;
        prv_mem[cur] <= tail;
        if (tail != NIL) nxt_mem[tail[FRAME_BITS-1:0]] <= {1'b0, cur};
        else head <= {1'b0, cur};
        tail <= {1'b0, cur};
        total <= total + 1'b1;
      end
      if (cmd.ins_wr && rd_pres) st <= ST_ALREADY;
      if (cmd.ins_next) cur <= cur + 1'b1;
      if (cmd.decide) begin
        tgt <= (op == MODE_ALLOC) ? cur : first;
        unique case (op)
          MODE_ALLOC: begin
            if (st == ST_OK) begin
              unl <= 1'b1;
              rc_new <= REF_BITS'(1);
              cnt_mem[cur] <= REF_BITS'(1);
            end else tgt <= '0;
          end
          MODE_HOLD, MODE_DROP, MODE_RELEASE, MODE_QUERY: begin
            if (!rd_pres) st <= ST_NOT_PRESENT;
            else if (op == MODE_HOLD) begin
              if (rd_cnt == MAX_REF) begin
                st <= ST_OVERFLOW;
                rc_new <= rd_cnt;
              end else begin
                unl <= (rd_cnt == '0);
                rc_new <= rd_cnt + 1'b1;
                cnt_mem[cur] <= rd_cnt + 1'b1;
              end
            end else if (op == MODE_QUERY) rc_new <= rd_cnt;
            else if (rd_cnt == '0) st <= ST_UNDERFLOW;
            else begin
              rc_new <= rd_cnt - 1'b1;
              cnt_mem[cur] <= rd_cnt - 1'b1;
              if (rd_cnt == REF_BITS'(1)) app <= 1'b1;
              else if (op == MODE_RELEASE) st <= ST_HELD;
            end
          end
          default: ;
        endcase
      end
      if (cmd.unlink) begin
        if (rd_prv != NIL) nxt_mem[rd_prv[FRAME_BITS-1:0]] <= rd_nxt;
        else head <= rd_nxt;
        if (rd_nxt != NIL) prv_mem[rd_nxt[FRAME_BITS-1:0]] <= rd_prv;
        else tail <= rd_prv;
        if (total != '0) total <= total - 1'b1;
      end
      if (cmd.append) begin
        nxt_mem[cur] <= NIL;
        prv_mem[cur] <= tail;
        if (tail != NIL) nxt_mem[tail[FRAME_BITS-1:0]] <= {1'b0, cur};
        else head <= {1'b0, cur};
        tail <= {1'b0, cur};
        total <= total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_frame <= (op == MODE_INSERT) ? first : tgt;
      ref_count <= 16'(rc_new);
      status <= st;
      free_frames <= 11'(total);
    end
  end
endmodule
`default_nettype wire

@@ design/rpfa_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module rpfa_ctrl import rpfa_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic [2:0] mode,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  state_t state, state_next;
  logic [2:0] op;
  logic out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) op <= mode;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clr_last) state_next = S_IDLE;
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = (op == MODE_INSERT) ? (sts.ins_ok ? S_INS_WR : S_DONE) : S_DECIDE;
      S_INS_WR: state_next = sts.ins_last ? S_DONE : S_INS_RD;
      S_INS_RD: state_next = S_INS_WR;
      S_DECIDE: state_next = S_UNLINK;
      S_UNLINK: state_next = S_APPEND;
      S_APPEND: state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != S_IDLE);
    unique case (state)
      S_CLEAR: cmd.clear = 1'b1;
      S_IDLE: cmd.load = in_valid;
      S_READ: cmd.rd = 1'b1;
      S_INS_RD: cmd.rd = 1'b1;
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        cmd.ins_next = !sts.ins_last;
      end
      S_DECIDE: cmd.decide = 1'b1;
      S_UNLINK: cmd.unlink = sts.do_unlink;
      S_APPEND: cmd.append = sts.do_append;
      S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ design/refcounted_page_frame_allocator.sv @@
// Reference-counted page frame allocator.
// Input channel (in_valid/in_stall) carries mode, frame, count; the output
// channel (out_valid/out_stall) carries result_frame, ref_count, status and
// free_frames, one result per transfer in.
// Flow: alloc, hold, drop, release and query pass through the read, decide,
// unlink, append and done states from accept to result; a valid insert walks
// its range with the single memory port, which reads then writes one frame
// per step, and an insert with a bad range goes from the read state straight
// to the done state.
// One item is worked at a time; the next is taken once its result sits in
// the output register, so a stalled output holds the block after one item.
// Reset empties the free list, then a pass over all 1024 frames clears the present
// marks one per cycle with in_stall high; counts and links need no clearing.
// While out_stall is high the result and out_valid hold.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_page_frame_allocator import rpfa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  mode,
  input  wire logic [9:0]  frame,
  input  wire logic [10:0] count,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       result_frame,
  output logic [15:0]      ref_count,
  output logic [2:0]       status,
  output logic [10:0]      free_frames
);
  cmd_t cmd;
  sts_t sts;

  rpfa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .mode, .out_valid, .out_stall, .sts, .cmd
  );

  rpfa_datapath u_dp (
    .clk, .rst, .mode, .frame, .count, .cmd, .sts,
    .result_frame, .ref_count, .status, .free_frames
  );
endmodule
`default_nettype wire

@@ test/refcounted_page_frame_allocator_test.sv @@
`timescale 1ns / 1ps
module refcounted_page_frame_allocator_test;
  import rpfa_pkg::*;

  typedef struct packed {
    logic [9:0]  frm;
    logic [15:0] refs;
    logic [2:0]  st;
    logic [10:0] nfree;
  } outcome_t;

  class frame_pool_board;
    bit [15:0] refs[NUM_FRAMES];
    bit        present[NUM_FRAMES];
    int        nxt[NUM_FRAMES];
    int        prv[NUM_FRAMES];
    int        head, tail, nfree;
    outcome_t  pending[$];
    int        errors;

    function new();
      head = NUM_FRAMES;
      tail = NUM_FRAMES;
      nfree = 0;
      errors = 0;
      foreach (present[i]) present[i] = 0;
    endfunction

    function void link_tail(int f);
      nxt[f] = NUM_FRAMES;
      prv[f] = tail;
      if (tail < NUM_FRAMES) nxt[tail] = f;
      else head = f;
      tail = f;
      nfree++;
    endfunction

    function void unlink(int f);
      int p, n;
      p = prv[f];
      n = nxt[f];
      if (p < NUM_FRAMES) nxt[p] = n;
      else head = n;
      if (n < NUM_FRAMES) prv[n] = p;
      else tail = p;
      if (nfree > 0) nfree--;
    endfunction

    function void note_request(logic [2:0] md, int f, int cnt);
      outcome_t o;
      o.frm = f[9:0];
      o.refs = 0;
      o.st = ST_OK;
      if (md == MODE_INSERT) begin
        if (cnt == 0 || f + cnt > NUM_FRAMES) o.st = ST_RANGE;
        else
          for (int g = f; g < f + cnt; g++) begin
            if (present[g]) o.st = ST_ALREADY;
            else begin
              present[g] = 1;
              refs[g] = 0;
              link_tail(g);
            end
          end
      end else if (md == MODE_ALLOC) begin
        if (head >= NUM_FRAMES) begin
          o.st = ST_EXHAUSTED;
          o.frm = 0;
        end else begin
          o.frm = head[9:0];
          refs[head] = 1;
          o.refs = 1;
          unlink(head);
        end
      end else if (md >= MODE_HOLD && md <= MODE_QUERY) begin
        if (!present[f]) o.st = ST_NOT_PRESENT;
        else begin
          if (md == MODE_HOLD) begin
            if (refs[f] == MAX_REF) o.st = ST_OVERFLOW;
            else begin
              if (refs[f] == 0) unlink(f);
              refs[f]++;
            end
          end else if (md == MODE_DROP || md == MODE_RELEASE) begin
            if (refs[f] == 0) o.st = ST_UNDERFLOW;
            else begin
              refs[f]--;
              if (refs[f] == 0) link_tail(f);
              else if (md == MODE_RELEASE) o.st = ST_HELD;
            end
          end
          o.refs = refs[f];
        end
      end else o.st = ST_RANGE;
      o.nfree = nfree[10:0];
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.frm !== exp.frm)
        $display("%0t: result_frame exp %0d got %0d", $time, exp.frm, got.frm);
      if (got.refs !== exp.refs)
        $display("%0t: ref_count exp %0d got %0d", $time, exp.refs, got.refs);
      if (got.st !== exp.st)
        $display("%0t: status exp %0d got %0d", $time, exp.st, got.st);
      if (got.nfree !== exp.nfree)
        $display("%0t: free_frames exp %0d got %0d", $time, exp.nfree, got.nfree);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [2:0] mode = 0;
  logic [9:0] frame = 0;
  logic [10:0] count = 0;
  wire in_stall, out_valid;
  wire [9:0] result_frame;
  wire [15:0] ref_count;
  wire [2:0] status;
  wire [10:0] free_frames;
  bit drain_done = 0;
  bit calm = 0;
  int stall_left = 0;

  frame_pool_board pool = new();

  refcounted_page_frame_allocator DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // hold valid across a zero gap so the next item follows straight on
  task automatic issue(logic [2:0] md, int f, int cnt);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    mode <= md;
    frame <= f[9:0];
    count <= cnt[10:0];
    do @(posedge clk); while (in_stall);
    pool.note_request(md, f, cnt);
  endtask

  // drop valid and hold until every expected result has come
  task automatic drain();
    in_valid <= 0;
    while (pool.pending.size() != 0) @(posedge clk);
  endtask

  // random frame, mostly one already present
  function automatic int pick_frame();
    int f;
    for (int k = 0; k < 8; k++) begin
      f = $urandom_range(0, NUM_FRAMES - 1);
      if (pool.present[f]) return f;
    end
    return f;
  endfunction

  // after each transfer out, stall for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      pool.check_result({result_frame, ref_count, status, free_frames});
      stall_left = calm ? 0 : $urandom_range(0, 9);
    end
    if (rst || calm || stall_left == 0) out_stall <= 0;
    else begin
      out_stall <= 1;
      stall_left--;
    end
  end

  initial begin
    int f, r;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed part
    issue(MODE_ALLOC, 0, 0);
    issue(MODE_QUERY, 5, 0);
    issue(MODE_HOLD, 1023, 0);
    issue(MODE_INSERT, 0, 0);
    issue(MODE_INSERT, 1000, 25);
    issue(MODE_INSERT, 1020, 4);
    issue(MODE_INSERT, 0, 8);
    issue(MODE_INSERT, 4, 8);
    issue(MODE_ALLOC, 1023, 2047);
    issue(MODE_HOLD, 1023, 0);
    issue(MODE_HOLD, 1023, 0);
    issue(MODE_RELEASE, 1023, 0);
    issue(MODE_DROP, 1023, 0);
    issue(MODE_DROP, 1023, 0);
    issue(MODE_RELEASE, 0, 0);
    issue(MODE_QUERY, 1021, 0);
    issue(MODE_RSVD_LO, 77, 3);
    issue(MODE_RSVD_HI, 1023, 0);
    issue(MODE_DROP, 500, 0);
    // back-to-back holds on frame 5 with no stalls
    calm = 1;
    for (int i = 0; i < 20; i++) issue(MODE_HOLD, 5, 0);
    issue(MODE_RELEASE, 5, 0);
    issue(MODE_HOLD, 5, 0);
    calm = 0;
    drain();
    for (int n = 0; n < 1900; n++) begin
      r = $urandom_range(0, 99);
      f = pick_frame();
      if (r < 4) issue(MODE_INSERT, $urandom_range(0, 1023), $urandom_range(1, 24));
      else if (r < 5) issue(MODE_INSERT, $urandom_range(0, 1023), $urandom_range(0, 2047));
      else if (r < 22) issue(MODE_ALLOC, $urandom_range(0, 1023), $urandom_range(0, 2047));
      else if (r < 45) issue(MODE_HOLD, f, $urandom_range(0, 2047));
      else if (r < 65) issue(MODE_DROP, f, 0);
      else if (r < 82) issue(MODE_RELEASE, f, 0);
      else if (r < 96) issue(MODE_QUERY, f, 0);
      else issue(3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI)), f, $urandom_range(0, 2047));
      if (n == 900) drain();
    end
    drain();
    repeat (60) @(posedge clk);
    if (pool.errors == 0) $display("status: pass");
    else $display("status: fail");
    drain_done = 1;
    $finish;
  end

  initial begin
    #200ms;
    if (!drain_done) $display("status: fail");
    $finish;
  end
endmodule
